[src/bbl_pkg.sv]
// shared constants, codes and types of the per-channel box blur
package bbl_pkg;

  // default sizes of the frame and the largest radius
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_RADIUS = 200;

  // pixel and field widths
  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int CH_MAX    = 255;
  localparam int IDX_W     = 18;
  localparam int CFG_DIM_W = 10;
  localparam int CFG_RAD_W = 8;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  // item modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_RUN    = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result status
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  // register indexes
  localparam logic [2:0] REG_RED    = 3'd0;
  localparam logic [2:0] REG_GREEN  = 3'd1;
  localparam logic [2:0] REG_BLUE   = 3'd2;
  localparam logic [2:0] REG_ALPHA  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  // one result item
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             status;
  } res_t;

endpackage

[src/bbl_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit a channel
module bbl_div import bbl_pkg::*; #(
  parameter int NW = 26,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [CH_W-1:0] quo
);

  localparam int SW = DW + CH_W;
  localparam int CNT_W = (CH_W > 1) ? $clog2(CH_W) : 1;

  logic          busy_r;
  logic          done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dsh_r;
  logic [CH_W-1:0] quo_r;
  logic          ge;

  assign ge   = (rem_r >= dsh_r);
  assign done = done_r;
  assign quo  = quo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CH_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, msb of the quotient first
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SW'(num);
      dsh_r <= SW'(den) << (CH_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[CH_W-2:0], ge};
    end
  end

endmodule

[src/bbl_engine.sv]
// frame and row-sum memories with the item and blur sequencer
module bbl_engine import bbl_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  localparam int XW = $clog2(MAX_WIDTH + 1),
  localparam int YW = $clog2(MAX_HEIGHT + 1),
  localparam int RW = $clog2(MAX_RADIUS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [1:0]               mode,
  input  logic [IDX_W-1:0]         idx,
  input  logic [PIX_W-1:0]         pix,
  output logic                     ready,
  input  logic [XW-1:0]            w,
  input  logic [YW-1:0]            h,
  input  logic [NUM_CH-1:0][RW-1:0] radii,
  output logic                     res_valid,
  output res_t                     res,
  input  logic                     res_take
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW      = (AW > IDX_W) ? AW : IDX_W;
  localparam int PW      = XW + YW;
  localparam int CPW     = IW + PW;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW      = $clog2(MAX_DIM + MAX_RADIUS + 2) + 1;
  localparam int SPAN    = 2 * MAX_RADIUS + 1;
  localparam int HW      = $clog2(SPAN * CH_MAX + 1);
  localparam int VW      = $clog2(SPAN * SPAN * CH_MAX + 1);
  localparam int AWD     = $clog2(SPAN * SPAN + 1);
  localparam int CHI_W   = $clog2(NUM_CH);

  localparam logic signed [CW-1:0] C_ZERO = '0;
  localparam logic signed [CW-1:0] C_ONE  = CW'(1);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CH      = 4'd1;
  localparam logic [3:0] S_HI_RD   = 4'd2;
  localparam logic [3:0] S_HI_ACC  = 4'd3;
  localparam logic [3:0] S_HX_WR   = 4'd4;
  localparam logic [3:0] S_HX_ADD  = 4'd5;
  localparam logic [3:0] S_HX_SUB  = 4'd6;
  localparam logic [3:0] S_VI_RD   = 4'd7;
  localparam logic [3:0] S_VI_ACC  = 4'd8;
  localparam logic [3:0] S_V_START = 4'd9;
  localparam logic [3:0] S_V_WAIT  = 4'd10;
  localparam logic [3:0] S_V_WB    = 4'd11;
  localparam logic [3:0] S_V_ADD   = 4'd12;
  localparam logic [3:0] S_V_SUB   = 4'd13;

  logic [3:0]             state_r;
  logic [CHI_W-1:0]       ch_r;
  logic [RW-1:0]          rad_r;
  logic [AWD-1:0]         area_r;
  logic signed [CW-1:0]   x_r, y_r, d_r;
  logic [AW-1:0]          base_r;
  logic [AW-1:0]          va_r;
  logic [VW-1:0]          sum_r;
  logic                   pend_r, pend_rd_r, pend_stat_r;

  // memories
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [HW-1:0]    sum_mem   [DEPTH];
  logic [PIX_W-1:0] f_rdata_r;
  logic [HW-1:0]    s_rdata_r;
  logic             f_we, f_re, s_we, s_re;
  logic [AW-1:0]    f_waddr, f_raddr, s_waddr, s_raddr;
  logic [PIX_W-1:0] f_wdata;

  logic                 acc;
  logic [IW-1:0]        idx_ext;
  logic [AW-1:0]        idx_addr;
  logic [PW-1:0]        npix;
  logic                 in_frame;
  logic signed [CW-1:0] r_s, w_s, h_s, hsel, vsel, hcol, vrow;
  logic [PW-1:0]        vprod;
  logic [AW-1:0]        haddr, vaddr;
  logic [CH_W-1:0]      chan;
  logic [VW-1:0]        chan_ext, rs_ext;
  logic [PIX_W-1:0]     wb_pix;
  logic                 x_last, y_last, d_last, ch_last;
  logic [RW-1:0]        rad_c;
  logic [RW:0]          span_c;
  logic [2*RW+1:0]      area_c;
  logic                 div_done;
  logic [CH_W-1:0]      div_q;

  function automatic logic [HW-1:0] s_wdata_sel(input logic [VW-1:0] v);
    return v[HW-1:0];
  endfunction

  // item handshake and range check
  assign ready    = (state_r == S_IDLE) && (!pend_r || res_take);
  assign acc      = in_valid && ready;
  assign idx_ext  = IW'(idx);
  assign idx_addr = idx_ext[AW-1:0];
  assign npix     = PW'(w) * PW'(h);
  assign in_frame = CPW'(idx_ext) < CPW'(npix);

  // coordinates and flags
  assign r_s     = $signed(CW'(rad_r));
  assign w_s     = $signed(CW'(w));
  assign h_s     = $signed(CW'(h));
  assign x_last  = (x_r == w_s - C_ONE);
  assign y_last  = (y_r == h_s - C_ONE);
  assign d_last  = (d_r == r_s);
  assign ch_last = (ch_r == CHI_W'(NUM_CH - 1));

  // horizontal tap, clamped to the row
  always_comb begin
    case (state_r)
      S_HX_WR:  hsel = x_r + r_s + C_ONE;
      S_HX_ADD: hsel = x_r - r_s;
      default:  hsel = d_r;
    endcase
    if (hsel < C_ZERO) hcol = C_ZERO;
    else if (hsel >= w_s) hcol = w_s - C_ONE;
    else hcol = hsel;
  end

  // vertical tap, clamped to the column
  always_comb begin
    case (state_r)
      S_V_WB:    vsel = y_r + r_s + C_ONE;
      S_V_ADD:   vsel = y_r - r_s;
      S_V_START: vsel = y_r;
      default:   vsel = d_r;
    endcase
    if (vsel < C_ZERO) vrow = C_ZERO;
    else if (vsel >= h_s) vrow = h_s - C_ONE;
    else vrow = vsel;
  end

  assign haddr    = base_r + AW'(hcol[XW-1:0]);
  assign vprod    = PW'(vrow[YW-1:0]) * PW'(w);
  assign vaddr    = AW'(vprod) + AW'(x_r[XW-1:0]);
  assign chan     = f_rdata_r[ch_r*CH_W +: CH_W];
  assign chan_ext = VW'(chan);
  assign rs_ext   = VW'(s_rdata_r);

  // write-back pixel with the blurred channel replaced
  always_comb begin
    wb_pix = f_rdata_r;
    wb_pix[ch_r*CH_W +: CH_W] = div_q;
  end

  // radius and box area of the channel in turn
  assign rad_c  = radii[ch_r];
  assign span_c = {rad_c, 1'b1};
  assign area_c = (2*RW+2)'(span_c) * (2*RW+2)'(span_c);

  // memory port control
  always_comb begin
    f_we    = 1'b0;
    f_re    = 1'b0;
    s_we    = 1'b0;
    s_re    = 1'b0;
    f_waddr = va_r;
    f_raddr = haddr;
    f_wdata = wb_pix;
    s_waddr = base_r + AW'(x_r[XW-1:0]);
    s_raddr = vaddr;
    case (state_r)
      S_IDLE: begin
        if (acc && in_frame && mode == MODE_WRITE) begin
          f_we    = 1'b1;
          f_waddr = idx_addr;
          f_wdata = pix;
        end
        if (acc && in_frame && mode == MODE_READ) begin
          f_re    = 1'b1;
          f_raddr = idx_addr;
        end
      end
      S_HI_RD:  f_re = 1'b1;
      S_HX_WR: begin
        s_we = 1'b1;
        f_re = !x_last;
      end
      S_HX_ADD: f_re = 1'b1;
      S_VI_RD:  s_re = 1'b1;
      S_V_START: begin
        f_re    = 1'b1;
        f_raddr = vaddr;
      end
      S_V_WB: begin
        f_we = 1'b1;
        s_re = !y_last;
      end
      S_V_ADD:  s_re = 1'b1;
      default: ;
    endcase
  end

  // frame store
  always_ff @(posedge clk) begin
    if (f_we) frame_mem[f_waddr] <= f_wdata;
    if (f_re) f_rdata_r <= frame_mem[f_raddr];
  end

  // row sum store
  always_ff @(posedge clk) begin
    if (s_we) sum_mem[s_waddr] <= s_wdata_sel(sum_r);
    if (s_re) s_rdata_r <= sum_mem[s_raddr];
  end

  // box average divider
  bbl_div #(
    .NW (VW),
    .DW (AWD)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_V_START),
    .num   (sum_r),
    .den   (area_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      pend_rd_r   <= 1'b0;
      pend_stat_r <= STAT_OK;
      ch_r        <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (mode)
              MODE_WRITE: begin
                pend_r      <= 1'b1;
                pend_rd_r   <= 1'b0;
                pend_stat_r <= in_frame ? STAT_OK : STAT_RANGE;
              end
              MODE_READ: begin
                pend_r      <= 1'b1;
                pend_rd_r   <= in_frame;
                pend_stat_r <= in_frame ? STAT_OK : STAT_RANGE;
              end
              MODE_RUN: begin
                pend_r  <= 1'b0;
                ch_r    <= '0;
                state_r <= S_CH;
              end
              default: begin
                pend_r      <= 1'b1;
                pend_rd_r   <= 1'b0;
                pend_stat_r <= STAT_OK;
              end
            endcase
          end else if (res_take) begin
            pend_r <= 1'b0;
          end
        end
        S_CH: begin
          if (rad_c == '0) begin
            if (ch_last) begin
              pend_r      <= 1'b1;
              pend_rd_r   <= 1'b0;
              pend_stat_r <= STAT_OK;
              state_r     <= S_IDLE;
            end else begin
              ch_r <= ch_r + CHI_W'(1);
            end
          end else begin
            rad_r   <= rad_c;
            area_r  <= AWD'(area_c);
            y_r     <= C_ZERO;
            base_r  <= '0;
            d_r     <= -$signed(CW'(rad_c));
            sum_r   <= '0;
            state_r <= S_HI_RD;
          end
        end
        // first window of a row
        S_HI_RD: state_r <= S_HI_ACC;
        S_HI_ACC: begin
          sum_r <= sum_r + chan_ext;
          if (d_last) begin
            x_r     <= C_ZERO;
            state_r <= S_HX_WR;
          end else begin
            d_r     <= d_r + C_ONE;
            state_r <= S_HI_RD;
          end
        end
        // slide along the row
        S_HX_WR: begin
          if (x_last) begin
            d_r   <= -r_s;
            sum_r <= '0;
            if (y_last) begin
              x_r     <= C_ZERO;
              state_r <= S_VI_RD;
            end else begin
              y_r     <= y_r + C_ONE;
              base_r  <= base_r + AW'(w);
              state_r <= S_HI_RD;
            end
          end else begin
            state_r <= S_HX_ADD;
          end
        end
        S_HX_ADD: begin
          sum_r   <= sum_r + chan_ext;
          state_r <= S_HX_SUB;
        end
        S_HX_SUB: begin
          sum_r   <= sum_r - chan_ext;
          x_r     <= x_r + C_ONE;
          state_r <= S_HX_WR;
        end
        // first window of a column
        S_VI_RD: state_r <= S_VI_ACC;
        S_VI_ACC: begin
          sum_r <= sum_r + rs_ext;
          if (d_last) begin
            y_r     <= C_ZERO;
            state_r <= S_V_START;
          end else begin
            d_r     <= d_r + C_ONE;
            state_r <= S_VI_RD;
          end
        end
        // divide and write back, then slide down the column
        S_V_START: begin
          va_r    <= vaddr;
          state_r <= S_V_WAIT;
        end
        S_V_WAIT: begin
          if (div_done) state_r <= S_V_WB;
        end
        S_V_WB: begin
          if (y_last) begin
            if (x_last) begin
              if (ch_last) begin
                pend_r      <= 1'b1;
                pend_rd_r   <= 1'b0;
                pend_stat_r <= STAT_OK;
                state_r     <= S_IDLE;
              end else begin
                ch_r    <= ch_r + CHI_W'(1);
                state_r <= S_CH;
              end
            end else begin
              x_r     <= x_r + C_ONE;
              d_r     <= -r_s;
              sum_r   <= '0;
              state_r <= S_VI_RD;
            end
          end else begin
            state_r <= S_V_ADD;
          end
        end
        S_V_ADD: begin
          sum_r   <= sum_r + rs_ext;
          state_r <= S_V_SUB;
        end
        S_V_SUB: begin
          sum_r   <= sum_r - rs_ext;
          y_r     <= y_r + C_ONE;
          state_r <= S_V_START;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // pending result
  assign res_valid  = pend_r;
  assign res.pixel  = pend_rd_r ? f_rdata_r : '0;
  assign res.status = pend_stat_r;

endmodule

[src/per_channel_box_blur_unit.sv]
// top level: register port, item channels and result register of the box blur
//
// The block holds one RGBA frame (channel 0 in the low byte) in an on-chip store.
// Items arrive on the in_ channel (valid/stall) and each gives one result item on
// the out_ channel. A write item stores a pixel, a read item returns one, a run
// item blurs every channel whose radius is nonzero in place.
// Write and read items are taken in the idle state; each result is registered in the
// engine's pending slot and then in the output register before it shows on the out_
// channel, and while the out_ channel does not stall, one item per cycle streams
// through the frame store. A run walks the frame through the frame store and the
// row sum store, per blurred channel first along every row and then down every
// column, where each pixel waits on the divider before it is written back.
// The radii, width and height registers sit on the APB port at byte address
// 4*index; write them only while no item is in flight.
// Reset clears the control state and sets the registers to their reset values;
// the frame store is undefined until written.
// A stalled result waits in the output register while the next item may still be
// taken and worked on; that item's result then waits inside until the slot frees.
module per_channel_box_blur_unit import bbl_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [IDX_W-1:0]  in_pixel_index,
  input  logic [PIX_W-1:0]  in_pixel_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_pixel_out,
  output logic              out_status
);

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_RADIUS + 1);

  logic [NUM_CH-1:0][CFG_RAD_W-1:0] rad_r;
  logic [CFG_DIM_W-1:0]             width_r, height_r;
  logic [2:0]                       reg_idx;
  logic                             cfg_wr;
  logic [XW-1:0]                    w_fit;
  logic [YW-1:0]                    h_fit;
  logic [NUM_CH-1:0][RW-1:0]        rad_fit;
  logic                             eng_ready, res_valid, res_take;
  res_t                             res;
  logic                             out_valid_r;
  res_t                             out_r;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r    <= '0;
      width_r  <= CFG_DIM_W'(512);
      height_r <= CFG_DIM_W'(512);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RED:    rad_r[0] <= pwdata[CFG_RAD_W-1:0];
        REG_GREEN:  rad_r[1] <= pwdata[CFG_RAD_W-1:0];
        REG_BLUE:   rad_r[2] <= pwdata[CFG_RAD_W-1:0];
        REG_ALPHA:  rad_r[3] <= pwdata[CFG_RAD_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RED:    prdata = APB_DW'(rad_r[0]);
      REG_GREEN:  prdata = APB_DW'(rad_r[1]);
      REG_BLUE:   prdata = APB_DW'(rad_r[2]);
      REG_ALPHA:  prdata = APB_DW'(rad_r[3]);
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  // frame size and radii held to their legal ranges
  always_comb begin
    if (width_r == '0) w_fit = XW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_fit = XW'(MAX_WIDTH);
    else w_fit = XW'(width_r);
    if (height_r == '0) h_fit = YW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_fit = YW'(MAX_HEIGHT);
    else h_fit = YW'(height_r);
    for (int i = 0; i < NUM_CH; i++) begin
      if (32'(rad_r[i]) > MAX_RADIUS) rad_fit[i] = RW'(MAX_RADIUS);
      else rad_fit[i] = RW'(rad_r[i]);
    end
  end

  // store and sequencer
  bbl_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .mode      (in_mode),
    .idx       (in_pixel_index),
    .pix       (in_pixel_in),
    .ready     (eng_ready),
    .w         (w_fit),
    .h         (h_fit),
    .radii     (rad_fit),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign in_stall = !eng_ready;

  // output register
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_r.pixel;
  assign out_status    = out_r.status;

endmodule

[bench/per_channel_box_blur_unit_checker.sv]
// checker for the box blur: watches both channels and the register port, predicts and compares
`timescale 1ns / 100ps
`default_nettype none

module per_channel_box_blur_unit_checker import bbl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [IDX_W-1:0]  in_pixel_index,
  input  wire logic [PIX_W-1:0]  in_pixel_in,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [PIX_W-1:0]  out_pixel_out,
  input  wire logic              out_status,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);

  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  // shadow of the frame and the scratch row sums
  bit [PIX_W-1:0] frame_img [0:STORE_DEPTH-1];
  bit [16:0]      row_acc   [0:STORE_DEPTH-1];

  // shadow of the registers
  bit [CFG_RAD_W-1:0] radius_reg [0:NUM_CH-1];
  bit [CFG_DIM_W-1:0] width_reg;
  bit [CFG_DIM_W-1:0] height_reg;

  res_t expected_results[$];

  function automatic int unsigned clamp_coord(int v, int unsigned n);
    if (v < 0) return 0;
    if (v >= int'(n)) return n - 1;
    return v;
  endfunction

  function automatic int unsigned fit_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // separable box average of one channel, rows first, then columns
  function automatic void smear_channel(int unsigned w, int unsigned h, int unsigned sh,
                                        int unsigned r);
    int unsigned x, y, acc, base, addr, area;
    int d;
    area = (2 * r + 1) * (2 * r + 1);
    for (y = 0; y < h; y++) begin
      base = y * w;
      acc = 0;
      for (d = -int'(r); d <= int'(r); d++)
        acc += frame_img[base + clamp_coord(d, w)][sh +: 8];
      for (x = 0; x < w; x++) begin
        row_acc[base + x] = acc[16:0];
        acc += frame_img[base + clamp_coord(int'(x) + int'(r) + 1, w)][sh +: 8];
        acc -= frame_img[base + clamp_coord(int'(x) - int'(r), w)][sh +: 8];
      end
    end
    for (x = 0; x < w; x++) begin
      acc = 0;
      for (d = -int'(r); d <= int'(r); d++)
        acc += row_acc[clamp_coord(d, h) * w + x];
      for (y = 0; y < h; y++) begin
        addr = y * w + x;
        frame_img[addr][sh +: 8] = 8'((acc / area) & 255);
        acc += row_acc[clamp_coord(int'(y) + int'(r) + 1, h) * w + x];
        acc -= row_acc[clamp_coord(int'(y) - int'(r), h) * w + x];
      end
    end
  endfunction

  // expected result of one accepted item, updating the shadow frame
  function automatic res_t predict_item(logic [1:0] mode, logic [IDX_W-1:0] idx,
                                        logic [PIX_W-1:0] pix);
    res_t res;
    int unsigned w, h, r, c;
    w = fit_dim(width_reg, DEF_MAX_WIDTH);
    h = fit_dim(height_reg, DEF_MAX_HEIGHT);
    res.pixel = '0;
    res.status = STAT_OK;
    case (mode)
      MODE_WRITE: begin
        if (idx < w * h) frame_img[idx] = pix;
        else res.status = STAT_RANGE;
      end
      MODE_RUN: begin
        for (c = 0; c < NUM_CH; c++) begin
          r = (radius_reg[c] > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius_reg[c];
          if (r != 0) smear_channel(w, h, 8 * c, r);
        end
      end
      MODE_READ: begin
        if (idx < w * h) res.pixel = frame_img[idx];
        else res.status = STAT_RANGE;
      end
      default: ;
    endcase
    return res;
  endfunction

  // register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) radius_reg[i] <= '0;
      width_reg  <= CFG_DIM_W'(DEF_MAX_WIDTH);
      height_reg <= CFG_DIM_W'(DEF_MAX_HEIGHT);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[APB_AW-1:2])
        REG_RED:    radius_reg[0] <= pwdata[CFG_RAD_W-1:0];
        REG_GREEN:  radius_reg[1] <= pwdata[CFG_RAD_W-1:0];
        REG_BLUE:   radius_reg[2] <= pwdata[CFG_RAD_W-1:0];
        REG_ALPHA:  radius_reg[3] <= pwdata[CFG_RAD_W-1:0];
        REG_WIDTH:  width_reg     <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_reg    <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // accepted items and results
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      expected_results.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_item(in_mode, in_pixel_index, in_pixel_in));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result item with none expected: pixel %08h status %0b",
                     $realtime, out_pixel_out, out_status);
        end else begin
          want = expected_results.pop_front();
          if (want.pixel !== out_pixel_out || want.status !== out_status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result %0d: expected pixel %08h status %0b, got %08h status %0b",
                       $realtime, results_seen, want.pixel, want.status,
                       out_pixel_out, out_status);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

[bench/per_channel_box_blur_unit_tb.sv]
// testbench top for the box blur: clock, reset, register writes, item stimulus, verdict
`timescale 1ns / 100ps
`default_nettype none

module per_channel_box_blur_unit_tb;
  import bbl_pkg::*;

  localparam int TARGET_ITEMS = 650;
  localparam int LONG_HOLD    = 400;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid, in_stall;
  logic [1:0]        in_mode;
  logic [IDX_W-1:0]  in_pixel_index;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              out_valid, out_stall;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              out_status;
  int                fail_count, pending, results_seen;

  int                items_sent;
  int                runs_sent;
  int                phases_done;
  int unsigned       frame_w, frame_h;
  logic [IDX_W-1:0]  written_idx[$];

  per_channel_box_blur_unit i_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_mode, .in_pixel_index, .in_pixel_in,
    .out_valid, .out_stall, .out_pixel_out, .out_status
  );

  per_channel_box_blur_unit_checker i_checker (
    .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .in_mode, .in_pixel_index, .in_pixel_in,
    .out_valid, .out_stall, .out_pixel_out, .out_status,
    .fail_count, .pending, .results_seen
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int hold;
    bit held_long;
    held_long = 1'b0;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (!held_long && results_seen >= 120) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        hold = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 6);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one register write, setup then access
  task automatic write_reg(logic [2:0] idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item after a random gap, return at the edge it is taken
  task automatic send_item(logic [1:0] mode, logic [IDX_W-1:0] idx, logic [PIX_W-1:0] pix);
    int gap;
    gap = ((items_sent / 60) % 3 == 2) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_pixel_index <= idx;
    in_pixel_in    <= pix;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (mode == MODE_RUN) runs_sent++;
    if (mode == MODE_WRITE && idx < frame_w * frame_h) written_idx.push_back(idx);
  endtask

  // drop valid and wait for every result to come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w_reg, int unsigned h_reg, int unsigned r0,
                           int unsigned r1, int unsigned r2, int unsigned r3);
    write_reg(REG_RED, r0);
    write_reg(REG_GREEN, r1);
    write_reg(REG_BLUE, r2);
    write_reg(REG_ALPHA, r3);
    write_reg(REG_WIDTH, w_reg);
    write_reg(REG_HEIGHT, h_reg);
    frame_w = (w_reg == 0) ? 1 : (w_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w_reg);
    frame_h = (h_reg == 0) ? 1 : (h_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : h_reg);
    written_idx.delete();
  endtask

  function automatic int unsigned pick_radius();
    if ($urandom_range(0, 9) == 0) return $urandom_range(DEF_MAX_RADIUS, 255);
    return $urandom_range(0, 4);
  endfunction

  // stimulus
  initial begin
    int unsigned sel, area;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_mode = MODE_WRITE; in_pixel_index = '0; in_pixel_in = '0;
    items_sent = 0; runs_sent = 0; phases_done = 0;
    frame_w = DEF_MAX_WIDTH;
    frame_h = DEF_MAX_HEIGHT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-size frame at reset values: corners, extreme pixels, run with no radius
    send_item(MODE_WRITE, '0, '0);
    send_item(MODE_WRITE, '1, '1);
    send_item(MODE_READ, '0, '1);
    send_item(MODE_READ, '1, '0);
    send_item(MODE_RUN, '1, '1);
    send_item(MODE_READ, '1, '0);
    send_item(MODE_UNUSED, '1, '1);
    send_item(MODE_UNUSED, '0, '0);
    repeat (40) begin
      if ($urandom_range(0, 1) == 0)
        send_item(MODE_WRITE, IDX_W'($urandom), $urandom);
      else
        send_item(MODE_READ, written_idx[$urandom_range(0, written_idx.size() - 1)], $urandom);
    end
    drain();
    phases_done++;

    // zero sizes act as a single pixel, radii above the maximum are clamped
    set_frame(0, 0, 255, 255, 255, 255);
    send_item(MODE_WRITE, '0, 32'hC3A5_7F01);
    send_item(MODE_WRITE, 18'd1, '1);
    send_item(MODE_READ, 18'd5, '0);
    send_item(MODE_RUN, '0, '0);
    send_item(MODE_READ, '0, '0);
    drain();
    phases_done++;

    // width above the maximum, single row, index just past the frame
    set_frame(1023, 1, 0, 0, 0, 0);
    send_item(MODE_WRITE, 18'd511, 32'h8040_2010);
    send_item(MODE_WRITE, 18'd512, '1);
    send_item(MODE_READ, 18'd511, '0);
    send_item(MODE_READ, 18'd600, '0);
    drain();
    phases_done++;

    // random small frames: fill, then mixed traffic with occasional runs
    while (items_sent < TARGET_ITEMS) begin
      set_frame($urandom_range(1, 8), $urandom_range(1, 8),
                pick_radius(), pick_radius(), pick_radius(), pick_radius());
      area = frame_w * frame_h;
      for (int unsigned i = 0; i < area; i++)
        send_item(MODE_WRITE, IDX_W'(i), $urandom);
      repeat (40) begin
        sel = $urandom_range(0, 99);
        if (sel < 45)
          send_item(MODE_WRITE, IDX_W'($urandom_range(0, area - 1)), $urandom);
        else if (sel < 53)
          send_item(MODE_WRITE, IDX_W'($urandom_range(area, 262143)), $urandom);
        else if (sel < 83)
          send_item(MODE_READ, IDX_W'($urandom_range(0, area - 1)), $urandom);
        else if (sel < 91)
          send_item(MODE_READ, IDX_W'($urandom_range(area, 262143)), $urandom);
        else if (sel < 96)
          send_item(MODE_RUN, IDX_W'($urandom), $urandom);
        else
          send_item(MODE_UNUSED, IDX_W'($urandom), $urandom);
      end
      send_item(MODE_RUN, '0, '0);
      for (int unsigned i = 0; i < area; i++)
        send_item(MODE_READ, IDX_W'(i), '0);
      drain();
      phases_done++;
    end

    repeat (50) @(posedge clk);
    $display("covered %0d items with %0d blur runs over %0d frame settings",
             items_sent, runs_sent, phases_done);
    $display("%0d result items checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/bbl_pkg.sv
src/bbl_div.sv
src/bbl_engine.sv
src/per_channel_box_blur_unit.sv
bench/per_channel_box_blur_unit_checker.sv
bench/per_channel_box_blur_unit_tb.sv
